[sv/ssfi_pkg.sv]
`default_nettype none

package ssfi_pkg;

  // table geometry
  localparam int CAPACITY = 256;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths of the transaction payloads
  localparam int KEY_FW = 32;
  localparam int POS_FW = 8;
  localparam int CNT_FW = 9;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // request type codes
  localparam logic REQ_FIND   = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [KEY_FW-1:0] key_value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [POS_FW-1:0] position;
    logic [CNT_FW-1:0] entry_count;
  } rsp_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/ssfi_cell.sv]
`default_nettype none

module ssfi_cell (
  input  wire logic                clk,
  input  wire ssfi_pkg::cell_ctrl_t ctrl,
  input  wire ssfi_pkg::key_t      cmp_key,
  input  wire ssfi_pkg::key_t      ins_key,
  input  wire ssfi_pkg::key_t      prev_key,
  input  wire logic                prev_lt,
  input  wire logic                occ,
  output ssfi_pkg::key_t           key,
  output logic                     lt,
  output logic                     bnd,
  output logic                     hit
);
  import ssfi_pkg::*;

  logic eq;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt <= occ && (key < cmp_key);
      eq <= occ && (key == cmp_key);
    end
    // cells at or above the boundary move up one slot, boundary cell takes the new key
    if (ctrl.ins_en && !lt) begin
      key <= prev_lt ? ins_key : prev_key;
    end
  end

  // first cell whose key is not below the search key
  assign bnd = !lt && prev_lt;
  assign hit = bnd && eq;

endmodule

`default_nettype wire

[sv/sorted_set_find_or_insert.sv]
// the cells compare at the request transaction edge and the response resolves on the next edge
// when the response register is free
// a new request is taken only after the last one resolves, as the compare-then-shift pass must finish
// a waiting response does not hold off the compare of the next request, only its resolve
// reset: rst is synchronous and active high; clears entry count, state and response valid
// key storage is not cleared; entries at or above the entry count are never used
`default_nettype none

module sorted_set_find_or_insert (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire ssfi_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output ssfi_pkg::rsp_t      rsp
);
  import ssfi_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  state_t     state;
  key_t       key_q;      // key of the request in flight
  logic       want_ins;   // request asks for insert
  cnt_t       count;      // stored entries
  cnt_t       count_next;

  cell_ctrl_t ctrl;
  key_t       cmp_key;
  key_t       cell_key [CAPACITY];
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] bnd;
  logic [CAPACITY-1:0] hit;

  logic       found;
  logic       full;
  logic       do_ins;
  logic       resolve;
  idx_t       pos_idx;
  rsp_t       rsp_next;

  assign req_ready = (state == S_IDLE);
  // the cells compare straight off the request port when the transaction lands
  assign cmp_key   = KEY_W'(req.key_value);

  // resolve only once the response register is free
  assign resolve = (state == S_EVAL) && (!rsp_valid || rsp_ready);

  assign ctrl = '{cmp_en: req_valid && req_ready, ins_en: resolve && do_ins};

  // chain of cells: each cell sees its lower neighbor's key and compare flag
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (cnt_t'(i) < count);
    if (i == 0) begin : g_first
      ssfi_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .cmp_key  (cmp_key),
        .ins_key  (key_q),
        .prev_key (key_q),
        .prev_lt  (1'b1),
        .occ      (occ[i]),
        .key      (cell_key[i]),
        .lt       (lt[i]),
        .bnd      (bnd[i]),
        .hit      (hit[i])
      );
    end else begin : g_rest
      ssfi_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .cmp_key  (cmp_key),
        .ins_key  (key_q),
        .prev_key (cell_key[i-1]),
        .prev_lt  (lt[i-1]),
        .occ      (occ[i]),
        .key      (cell_key[i]),
        .lt       (lt[i]),
        .bnd      (bnd[i]),
        .hit      (hit[i])
      );
    end
  end

  // boundary is one-hot (or empty when a full table holds only smaller keys)
  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd[i]) begin
        pos_idx = pos_idx | idx_t'(i);
      end
    end
  end

  assign found  = |hit;
  assign full   = (count == cnt_t'(CAPACITY));
  assign do_ins = !found && (want_ins == REQ_INSERT) && !full;

  assign count_next = do_ins ? count + cnt_t'(1) : count;

  // response selection
  always_comb begin
    rsp_next.position    = '0;
    rsp_next.entry_count = CNT_FW'(count_next);
    if (found) begin
      rsp_next.status   = ST_FOUND;
      rsp_next.position = POS_FW'(pos_idx);
    end else if (want_ins == REQ_FIND) begin
      rsp_next.status = ST_NOT_FOUND;
    end else if (full) begin
      rsp_next.status = ST_FULL;
    end else begin
      rsp_next.status   = ST_INSERTED;
      rsp_next.position = POS_FW'(pos_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // a new response in the same cycle keeps valid high
      if (rsp_valid && rsp_ready && !resolve) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            key_q    <= cmp_key;
            want_ins <= req.req_type;
            state    <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (resolve) begin
            rsp       <= rsp_next;
            rsp_valid <= 1'b1;
            count     <= count_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/ssfi_checker.sv]
`default_nettype none

module ssfi_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire ssfi_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire ssfi_pkg::rsp_t rsp
);
  import ssfi_pkg::*;

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // one request in flight: busy the cycle after a transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // misses carry position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL) |->
      rsp.position == '0)
    else $error("nonzero position on miss");

  // a full report needs a full table
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == CNT_FW'(CAPACITY))
    else $error("full reported below capacity");

  // an inserted key sits below the new entry count
  a_ins_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_INSERTED |->
      CNT_FW'(rsp.position) < rsp.entry_count)
    else $error("insert position beyond entry count");

endmodule

bind sorted_set_find_or_insert ssfi_checker u_ssfi_checker (.*);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import ssfi_pkg::*;

  // run shape
  localparam int ITEM_TARGET  = 1950;
  localparam int GROW_LIMIT   = 1700;   // give up on random growth and fill directly
  localparam int FULL_MINIMUM = 200;    // transactions offered against a full table
  localparam int STALL_LIMIT  = 3000;   // cycles with no transaction on either channel
  localparam int DRAIN_CYCLES = 20;

  // clock and reset, all block inputs known from time zero
  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;

  sorted_set_find_or_insert dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: a plain sorted array with the same dedup and capacity rules
  // ---------------------------------------------------------------------------
  key_t set_keys [CAPACITY];
  int   set_size = 0;

  rsp_t pending_results [$];   // expected responses, oldest first
  key_t seen_keys [$];         // every key offered so far, reused to hit stored entries
  int   items_sent    = 0;
  int   mismatch_count = 0;

  function automatic rsp_t find_or_insert_model(req_t item);
    rsp_t res;
    int   slot;
    int   i;
    bit   hit;
    res  = '0;
    slot = 0;
    // first slot whose key is not below the request key
    while (slot < set_size && set_keys[slot] < item.key_value) slot++;
    hit = (slot < set_size) && (set_keys[slot] == item.key_value);
    if (hit) begin
      res.status   = ST_FOUND;
      res.position = slot[POS_FW-1:0];
    end else if (item.req_type == REQ_FIND) begin
      res.status = ST_NOT_FOUND;
    end else if (set_size >= CAPACITY) begin
      // absent key with no room left: nothing moves
      res.status = ST_FULL;
    end else begin
      // open the slot by moving every larger key up one place
      for (i = set_size; i > slot; i--) set_keys[i] = set_keys[i-1];
      set_keys[slot] = item.key_value;
      set_size++;
      res.status   = ST_INSERTED;
      res.position = slot[POS_FW-1:0];
    end
    res.entry_count = set_size[CNT_FW-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // random key choice: fresh keys, stored keys, their neighbors and the extremes
  // ---------------------------------------------------------------------------
  localparam key_t BOUNDARY_KEYS [6] = '{
    32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
    32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  function automatic key_t pick_key();
    int   roll;
    key_t k;
    roll = $urandom_range(99);
    if (seen_keys.size() == 0 || roll < 45) begin
      k = $urandom();
    end else if (roll < 75) begin
      k = seen_keys[$urandom_range(seen_keys.size() - 1)];
    end else if (roll < 90) begin
      // just above or below a known key, lands between neighbors
      k = seen_keys[$urandom_range(seen_keys.size() - 1)];
      k = ($urandom_range(1) != 0) ? k + 1'b1 : k - 1'b1;
    end else begin
      k = BOUNDARY_KEYS[$urandom_range(5)];
    end
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: random gaps, valid held until the transaction is taken
  // ---------------------------------------------------------------------------
  task automatic offer_request(input req_t item, input bit use_typed, input rsp_t typed_rsp);
    rsp_t predicted;
    bit   steady;
    // a stretch of back-to-back requests in the middle of the run
    steady = (items_sent >= 300 && items_sent < 600);
    if (!steady) begin
      while ($urandom_range(99) < 37) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    // transaction taken at this edge, predict in acceptance order
    predicted = find_or_insert_model(item);
    pending_results.push_back(use_typed ? typed_rsp : predicted);
    seen_keys.push_back(item.key_value);
    items_sent++;
  endtask

  task automatic offer_random(input int insert_pct);
    req_t item;
    item.req_type  = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_FIND;
    item.key_value = pick_key();
    offer_request(item, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // directed table; rows with typed = 0 are checked against the predictor
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic rtype;
    key_t key;
    logic typed;
    rsp_t want;
  } dir_row_t;

  localparam int DIRECTED_ROWS = 19;

  dir_row_t dir_rows [DIRECTED_ROWS] = '{
    // empty table: nothing to find at either extreme
    '{REQ_FIND,   32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 8'd0, 9'd0}},
    '{REQ_FIND,   32'hFFFF_FFFF, 1'b1, '{ST_NOT_FOUND, 8'd0, 9'd0}},
    // first insert lands at slot zero, a repeat is found there
    '{REQ_INSERT, 32'h8000_0000, 1'b1, '{ST_INSERTED,  8'd0, 9'd1}},
    '{REQ_INSERT, 32'h8000_0000, 1'b1, '{ST_FOUND,     8'd0, 9'd1}},
    '{REQ_FIND,   32'h8000_0000, 1'b1, '{ST_FOUND,     8'd0, 9'd1}},
    // smallest and largest keys, then neighbors of the midpoint
    '{REQ_INSERT, 32'h0000_0000, 1'b0, '0},
    '{REQ_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
    '{REQ_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
    '{REQ_INSERT, 32'h8000_0001, 1'b0, '0},
    '{REQ_FIND,   32'h0000_0000, 1'b0, '0},
    '{REQ_FIND,   32'hFFFF_FFFF, 1'b0, '0},
    '{REQ_FIND,   32'h7FFF_FFFE, 1'b0, '0},
    '{REQ_INSERT, 32'h0000_0001, 1'b0, '0},
    '{REQ_INSERT, 32'hFFFF_FFFE, 1'b0, '0},
    '{REQ_FIND,   32'h8000_0000, 1'b0, '0},
    // alternating bit patterns
    '{REQ_INSERT, 32'h5555_5555, 1'b0, '0},
    '{REQ_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
    '{REQ_FIND,   32'hAAAA_AAAA, 1'b0, '0},
    '{REQ_FIND,   32'h5555_5554, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // response side: checking against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  task automatic check_response(input rsp_t got);
    rsp_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected response, status", 32'(got.status), 0);
    end else begin
      want = pending_results.pop_front();
      if (got.status != want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.position != want.position)
        report_mismatch("position", 32'(got.position), 32'(want.position));
      if (got.entry_count != want.entry_count)
        report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
    end
  endtask

  // receiver: random stalls, one long hold-off so the block backs up into
  // the request side, and a stretch with no stalls at all
  initial begin : response_sink
    int results_seen;
    int hold_left;
    results_seen = 0;
    hold_left    = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) begin
        check_response(rsp);
        results_seen++;
        if (results_seen == 150) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (results_seen >= 1000 && results_seen < 1300) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= 37);
      end
    end
  end

  // watchdog: ends the run if no transaction moves on either channel for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    req_t item;
    int   full_items;
    full_items = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      item.req_type  = dir_rows[r].rtype;
      item.key_value = dir_rows[r].key;
      offer_request(item, dir_rows[r].typed, dir_rows[r].want);
    end

    // growth: mostly lookups, enough inserts to fill the table gradually
    while (set_size < CAPACITY && items_sent < GROW_LIMIT) offer_random(35);

    // top up with fresh keys if random growth fell short
    while (set_size < CAPACITY) begin
      item.req_type  = REQ_INSERT;
      item.key_value = $urandom();
      offer_request(item, 1'b0, '0);
    end

    // full table: absent inserts are refused, stored keys still found
    while (items_sent < ITEM_TARGET || full_items < FULL_MINIMUM) begin
      offer_random(50);
      full_items++;
    end
    req_valid <= 1'b0;

    // drain, then allow for any stray response
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
